// ----- src/tridiagonal_partition_reducer_assert.svh -----
// Assertion macros for the tridiagonal partition reducer.
`ifndef TRIDIAGONAL_PARTITION_REDUCER_ASSERT_SVH
`define TRIDIAGONAL_PARTITION_REDUCER_ASSERT_SVH
`ifndef SYNTH
// A condition that must hold at every clock edge outside reset.
`define TPR_ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// A condition that must hold in the cycle after a trigger.
`define TPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TPR_ASSERT_HOLDS(lbl, cond, msg)
`define TPR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/tpr_pkg.sv -----
// Shared types, constants and saturating fixed-point helpers of the reducer.
`timescale 1ns / 1ps
package tpr_pkg;

	localparam int MAX_ROWS  = 64;
	localparam int FRAC_BITS = 32;
	localparam int DATA_W    = 64;
	localparam int IDX_W     = $clog2(MAX_ROWS);
	localparam int CNT_W     = $clog2(MAX_ROWS + 1);
	localparam int DIV_STEPS = DATA_W + FRAC_BITS;
	localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

	typedef logic [DATA_W-1:0] word_t;

	localparam word_t FX_ONE   = word_t'(1) << FRAC_BITS;
	localparam word_t FX_MIN   = word_t'(1) << (DATA_W - 1);
	localparam word_t FX_MAX   = FX_MIN - word_t'(1);

	// Result kinds.
	localparam logic [1:0] KIND_REDUCED  = 2'd0;
	localparam logic [1:0] KIND_SOLUTION = 2'd1;
	localparam logic [1:0] KIND_ERROR    = 2'd2;

	// Error codes.
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_ZERO_PIVOT = 2'd1;
	localparam logic [1:0] ERR_FEW_ROWS   = 2'd2;
	localparam logic [1:0] ERR_NO_BLOCK   = 2'd3;

	typedef struct packed {
		logic               kind;
		logic signed [63:0] lower;
		logic signed [63:0] diag;
		logic signed [63:0] upper;
		logic signed [63:0] rhs;
		logic               last_row;
		logic signed [63:0] first_solution;
		logic signed [63:0] final_solution;
	} item_t;

	typedef struct packed {
		logic        [1:0]  out_kind;
		logic signed [63:0] reduced_lower;
		logic signed [63:0] reduced_upper;
		logic signed [63:0] value;
		logic        [5:0]  row_index;
		logic        [1:0]  error_code;
		logic               last;
	} result_t;

	// Magnitude of a two's complement word; the most negative value maps to 2^63.
	function automatic word_t fx_mag(input word_t x);
		return x[DATA_W-1] ? (word_t'(0) - x) : x;
	endfunction

	// Saturate a wide unsigned magnitude with a sign into one word.
	function automatic word_t fx_pack(input word_t hi, input word_t lo, input logic neg);
		word_t r;
		if (neg) begin
			r = ((hi != '0) || (lo > FX_MIN)) ? FX_MIN : (word_t'(0) - lo);
		end else begin
			r = ((hi != '0) || (lo > FX_MAX)) ? FX_MAX : lo;
		end
		return r;
	endfunction

	function automatic word_t fx_add(input word_t a, input word_t b);
		word_t s;
		s = a + b;
		if ((a[DATA_W-1] == b[DATA_W-1]) && (s[DATA_W-1] != a[DATA_W-1])) begin
			s = a[DATA_W-1] ? FX_MIN : FX_MAX;
		end
		return s;
	endfunction

	function automatic word_t fx_sub(input word_t a, input word_t b);
		word_t s;
		s = a - b;
		if ((a[DATA_W-1] != b[DATA_W-1]) && (s[DATA_W-1] != a[DATA_W-1])) begin
			s = a[DATA_W-1] ? FX_MIN : FX_MAX;
		end
		return s;
	endfunction

	function automatic word_t fx_neg(input word_t a);
		return fx_sub(word_t'(0), a);
	endfunction

endpackage

// ----- src/tpr_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module tpr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/tpr_mul.sv -----
// Multi-cycle saturating fixed-point multiplier built from 32x32 partial products.
`timescale 1ns / 1ps
module tpr_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tpr_pkg::word_t a,
	input  tpr_pkg::word_t b,
	output logic          done,
	output tpr_pkg::word_t y
);
	import tpr_pkg::*;

	localparam int HALF_W = DATA_W / 2;
	localparam logic [2:0] LAST_PP = 3'd3;

	logic                  busy_q;
	logic                  done_q;
	logic [2:0]            cnt_q;
	logic                  neg_q;
	word_t                 am_q;
	word_t                 bm_q;
	logic [2*DATA_W-1:0]   acc_q;
	word_t                 y_q;
	logic [HALF_W-1:0]     xa;
	logic [HALF_W-1:0]     xb;
	word_t                 pp;
	logic [2*DATA_W-1:0]   pp_sh;
	logic [2*DATA_W-1:0]   rnd;
	logic [2*DATA_W-1:0]   shr;

	// Pick the halves for this partial product and align it.
	always_comb begin
		xa = am_q[HALF_W-1:0];
		xb = bm_q[HALF_W-1:0];
		case (cnt_q[1:0])
			2'd1: xb = bm_q[DATA_W-1:HALF_W];
			2'd2: xa = am_q[DATA_W-1:HALF_W];
			2'd3: begin
				xa = am_q[DATA_W-1:HALF_W];
				xb = bm_q[DATA_W-1:HALF_W];
			end
			default: ;
		endcase
		pp = word_t'(xa) * word_t'(xb);
		case (cnt_q[1:0])
			2'd0:    pp_sh = {{DATA_W{1'b0}}, pp};
			2'd3:    pp_sh = {pp, {DATA_W{1'b0}}};
			default: pp_sh = {{DATA_W{1'b0}}, pp} << HALF_W;
		endcase
		rnd = acc_q + ((2*DATA_W)'(1) << (FRAC_BITS - 1));
		shr = rnd >> FRAC_BITS;
	end

	// Sequence: four partial products, then round and saturate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q <= LAST_PP) begin
					cnt_q <= cnt_q + 3'd1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and accumulator registers.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			am_q  <= fx_mag(a);
			bm_q  <= fx_mag(b);
			neg_q <= a[DATA_W-1] ^ b[DATA_W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q <= LAST_PP) begin
				acc_q <= acc_q + pp_sh;
			end else begin
				y_q <= fx_pack(shr[2*DATA_W-1:DATA_W], shr[DATA_W-1:0], neg_q);
			end
		end
	end

	assign done = done_q;
	assign y    = y_q;

endmodule

// ----- src/tpr_div.sv -----
// Restoring radix-2 fixed-point divider, one quotient bit per cycle, rounded and saturated.
`timescale 1ns / 1ps
module tpr_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tpr_pkg::word_t num,
	input  tpr_pkg::word_t den,
	output logic          done,
	output tpr_pkg::word_t quo
);
	import tpr_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DIV_CW-1:0]   cnt_q;
	logic                neg_q;
	word_t               nm_q;
	word_t               dm_q;
	word_t               rem_q;
	logic [2*DATA_W-1:0] q_q;
	word_t               y_q;
	logic [DATA_W:0]     trial;
	logic                take;
	logic [2*DATA_W-1:0] q_rnd;

	// One restoring step and the final rounding.
	always_comb begin
		trial = {rem_q, nm_q[DATA_W-1]};
		take  = (trial >= {1'b0, dm_q});
		q_rnd = (rem_q >= (dm_q - rem_q)) ? (q_q + (2*DATA_W)'(1)) : q_q;
	end

	// Step counter and completion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q != DIV_CW'(DIV_STEPS)) begin
					cnt_q <= cnt_q + DIV_CW'(1);
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend shifts out from the top; zeros follow for the fraction bits.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			nm_q  <= fx_mag(num);
			dm_q  <= fx_mag(den);
			neg_q <= num[DATA_W-1] ^ den[DATA_W-1];
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			if (cnt_q != DIV_CW'(DIV_STEPS)) begin
				nm_q <= {nm_q[DATA_W-2:0], 1'b0};
				if (take) begin
					rem_q <= word_t'(trial - {1'b0, dm_q});
					q_q   <= {q_q[2*DATA_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[DATA_W-1:0];
					q_q   <= {q_q[2*DATA_W-2:0], 1'b0};
				end
			end else begin
				y_q <= fx_pack(q_rnd[2*DATA_W-1:DATA_W], q_rnd[DATA_W-1:0], neg_q);
			end
		end
	end

	assign done = done_q;
	assign quo  = y_q;

endmodule

// ----- src/tridiagonal_partition_reducer.sv -----
// A row is eliminated by three multiplies on the shared multiplier and a divide; rows 0-1 skip the multiplies.
// The last row adds a backward sweep over the interior rows, then the final reduction of row 0.
// A boundary item gives one solution word per row; each interior row first takes two multiplies.
// One item is in work at a time; the multiplier, the dividers and the RAM read-modify-write set the pace.
// Reset clears the sequencer, counters and flags at once; the row stores hold no reset value
// and need no clearing pass, since only rows written in the current block are read.
`timescale 1ns / 1ps
`include "tridiagonal_partition_reducer_assert.svh"
module tridiagonal_partition_reducer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  tpr_pkg::item_t   item_word,
	output logic             result_valid,
	input  logic             result_stall,
	output tpr_pkg::result_t result_word
);
	import tpr_pkg::*;

	typedef enum logic [23:0] {
		S_IDLE     = 24'h000001,
		S_FWD_MUL  = 24'h000002,
		S_FWD_PIV  = 24'h000004,
		S_FWD_DIV  = 24'h000008,
		S_FWD_WR   = 24'h000010,
		S_CHECK    = 24'h000020,
		S_NX_RD    = 24'h000040,
		S_NX_CAP   = 24'h000080,
		S_BK_RD    = 24'h000100,
		S_BK_MUL   = 24'h000200,
		S_BK_WR    = 24'h000400,
		S_FIN_RD   = 24'h000800,
		S_FIN_MUL  = 24'h001000,
		S_FIN_DEN  = 24'h002000,
		S_FIN_DIV  = 24'h004000,
		S_EMIT0    = 24'h008000,
		S_LAST_RD  = 24'h010000,
		S_EMIT1    = 24'h020000,
		S_ERR      = 24'h040000,
		S_B_FIRST  = 24'h080000,
		S_B_RD     = 24'h100000,
		S_B_MUL    = 24'h200000,
		S_B_EMIT   = 24'h400000,
		S_B_LAST   = 24'h800000
	} state_t;

	state_t          state_q;
	item_t           item_q;
	logic [CNT_W-1:0] row_count_q;
	logic            block_ready_q;
	logic            zero_seen_q;
	logic [1:0]      err_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] rd_addr_q;
	logic [1:0]      mstep_q;
	logic            mul_busy_q;
	word_t           p0_q, p1_q, p2_q;
	word_t           wl_q, wu_q, wr_q;
	word_t           prev_lo_q, prev_up_q, prev_rh_q;
	word_t           nx_lo_q, nx_up_q, nx_rh_q;
	logic            result_valid_q;
	result_t         result_q;

	logic            accept;
	logic            out_free;
	logic [CNT_W-1:0] rc_eff;
	logic            mul_go, mul_done;
	logic [1:0]      mul_last;
	word_t           mul_a, mul_b, mul_y;
	logic            div_go;
	logic            div_done0, div_done1, div_done2;
	logic            div_done;
	word_t           div_den, div_n0, div_n1, div_n2;
	word_t           div_q0, div_q1, div_q2;
	logic            ram_we;
	logic [IDX_W-1:0] ram_waddr;
	word_t           ram_wl, ram_wu, ram_wr;
	word_t           rd_lo, rd_up, rd_rh;
	word_t           piv, fwd_lo, fwd_rh, fin_den;
	word_t           bk_lo, bk_up, bk_rh;
	word_t           sol_val;
	logic            res_load;
	result_t         res_d;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign out_free   = !result_valid_q || !result_stall;
	assign rc_eff     = block_ready_q ? '0 : row_count_q;

	// Row stores.
	tpr_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_lower_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wl),
		.raddr(rd_addr_q), .rdata(rd_lo)
	);
	tpr_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_upper_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wu),
		.raddr(rd_addr_q), .rdata(rd_up)
	);
	tpr_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_rhs_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wr),
		.raddr(rd_addr_q), .rdata(rd_rh)
	);

	// Shared multiplier and three dividers that run with one pivot.
	tpr_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go), .a(mul_a), .b(mul_b),
		.done(mul_done), .y(mul_y)
	);
	tpr_div u_div_lower (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num(div_n0), .den(div_den),
		.done(div_done0), .quo(div_q0)
	);
	tpr_div u_div_upper (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num(div_n1), .den(div_den),
		.done(div_done1), .quo(div_q1)
	);
	tpr_div u_div_rhs (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num(div_n2), .den(div_den),
		.done(div_done2), .quo(div_q2)
	);

	// The three quotients are ready together.
	assign div_done = div_done0 && div_done1 && div_done2;

	// Elimination arithmetic on registered products and read data.
	always_comb begin
		if (row_count_q >= CNT_W'(2)) begin
			piv    = fx_sub(item_q.diag, p0_q);
			fwd_rh = fx_sub(item_q.rhs, p1_q);
			fwd_lo = fx_neg(p2_q);
		end else begin
			piv    = item_q.diag;
			fwd_rh = item_q.rhs;
			fwd_lo = item_q.lower;
		end
		bk_rh   = fx_sub(rd_rh, p0_q);
		bk_lo   = fx_sub(rd_lo, p1_q);
		bk_up   = fx_neg(p2_q);
		fin_den = fx_sub(FX_ONE, p0_q);
		sol_val = fx_sub(rd_rh, fx_add(p0_q, p1_q));
	end

	// Multiplier operand selection by state and step.
	always_comb begin
		mul_a    = item_q.lower;
		mul_b    = prev_up_q;
		mul_last = (state_q == S_B_MUL) ? 2'd1 : 2'd2;
		mul_go   = !mul_busy_q && ((state_q == S_FWD_MUL) || (state_q == S_BK_MUL) ||
			(state_q == S_FIN_MUL) || (state_q == S_B_MUL));
		unique case (state_q)
			S_FWD_MUL: begin
				case (mstep_q)
					2'd0:    mul_b = prev_up_q;
					2'd1:    mul_b = prev_rh_q;
					default: mul_b = prev_lo_q;
				endcase
			end
			S_BK_MUL: begin
				mul_a = rd_up;
				case (mstep_q)
					2'd0:    mul_b = nx_rh_q;
					2'd1:    mul_b = nx_lo_q;
					default: mul_b = nx_up_q;
				endcase
			end
			S_FIN_MUL: begin
				case (mstep_q)
					2'd0: begin
						mul_a = nx_lo_q;
						mul_b = rd_up;
					end
					2'd1: begin
						mul_a = rd_up;
						mul_b = nx_rh_q;
					end
					default: begin
						mul_a = rd_up;
						mul_b = nx_up_q;
					end
				endcase
			end
			S_B_MUL: begin
				if (mstep_q == 2'd0) begin
					mul_a = rd_lo;
					mul_b = item_q.first_solution;
				end else begin
					mul_a = rd_up;
					mul_b = item_q.final_solution;
				end
			end
			default: ;
		endcase
	end

	// Divider start and operands.
	always_comb begin
		div_go  = 1'b0;
		div_den = piv;
		div_n0  = fwd_lo;
		div_n1  = item_q.upper;
		div_n2  = fwd_rh;
		if (state_q == S_FWD_PIV) begin
			div_go = (piv != '0);
		end else if (state_q == S_FIN_DEN) begin
			div_go  = (fin_den != '0);
			div_den = fin_den;
			div_n0  = rd_lo;
			div_n1  = fx_neg(p2_q);
			div_n2  = fx_sub(rd_rh, p1_q);
		end
	end

	// Row store write port.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = row_count_q[IDX_W-1:0];
		ram_wl    = wl_q;
		ram_wu    = wu_q;
		ram_wr    = wr_q;
		if (state_q == S_FWD_WR) begin
			ram_we = 1'b1;
		end else if (state_q == S_BK_WR) begin
			ram_we    = 1'b1;
			ram_waddr = i_q;
			ram_wl    = bk_lo;
			ram_wu    = bk_up;
			ram_wr    = bk_rh;
		end else if ((state_q == S_EMIT0) && out_free) begin
			ram_we    = 1'b1;
			ram_waddr = '0;
		end
	end

	// Result word for the emitting states.
	always_comb begin
		res_d            = '0;
		res_d.out_kind   = KIND_SOLUTION;
		res_d.error_code = ERR_NONE;
		res_load         = 1'b0;
		unique case (state_q)
			S_EMIT0: begin
				res_load            = out_free;
				res_d.out_kind      = KIND_REDUCED;
				res_d.reduced_lower = wl_q;
				res_d.reduced_upper = wu_q;
				res_d.value         = wr_q;
			end
			S_EMIT1: begin
				res_load            = out_free;
				res_d.out_kind      = KIND_REDUCED;
				res_d.reduced_lower = rd_lo;
				res_d.reduced_upper = rd_up;
				res_d.value         = rd_rh;
				res_d.row_index     = 6'(row_count_q - CNT_W'(1));
				res_d.last          = 1'b1;
			end
			S_ERR: begin
				res_load         = out_free;
				res_d.out_kind   = KIND_ERROR;
				res_d.error_code = err_q;
				res_d.last       = 1'b1;
			end
			S_B_FIRST: begin
				res_load    = out_free;
				res_d.value = item_q.first_solution;
			end
			S_B_EMIT: begin
				res_load        = out_free;
				res_d.value     = sol_val;
				res_d.row_index = 6'(i_q);
			end
			S_B_LAST: begin
				res_load        = out_free;
				res_d.value     = item_q.final_solution;
				res_d.row_index = 6'(row_count_q - CNT_W'(1));
				res_d.last      = 1'b1;
			end
			default: ;
		endcase
	end

	// Captured input word.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item_word;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			row_count_q   <= '0;
			block_ready_q <= 1'b0;
			zero_seen_q   <= 1'b0;
			err_q         <= ERR_NONE;
			i_q           <= '0;
			rd_addr_q     <= '0;
			mstep_q       <= '0;
			mul_busy_q    <= 1'b0;
			p0_q          <= '0;
			p1_q          <= '0;
			p2_q          <= '0;
			wl_q          <= '0;
			wu_q          <= '0;
			wr_q          <= '0;
			prev_lo_q     <= '0;
			prev_up_q     <= '0;
			prev_rh_q     <= '0;
			nx_lo_q       <= '0;
			nx_up_q       <= '0;
			nx_rh_q       <= '0;
		end else begin
			// Shared multiplier handshake.
			if (mul_go) begin
				mul_busy_q <= 1'b1;
			end else if (mul_done) begin
				mul_busy_q <= 1'b0;
				case (mstep_q)
					2'd0:    p0_q <= mul_y;
					2'd1:    p1_q <= mul_y;
					default: p2_q <= mul_y;
				endcase
				if (mstep_q == mul_last) begin
					mstep_q <= '0;
				end else begin
					mstep_q <= mstep_q + 2'd1;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item_word.kind) begin
							if (!block_ready_q) begin
								err_q   <= ERR_NO_BLOCK;
								state_q <= S_ERR;
							end else begin
								state_q <= S_B_FIRST;
							end
						end else begin
							if (block_ready_q) begin
								block_ready_q <= 1'b0;
								row_count_q   <= '0;
								zero_seen_q   <= 1'b0;
							end
							if (rc_eff < CNT_W'(MAX_ROWS)) begin
								state_q <= (rc_eff >= CNT_W'(2)) ? S_FWD_MUL : S_FWD_PIV;
							end else if (item_word.last_row) begin
								state_q <= S_CHECK;
							end
						end
					end
				end
				S_FWD_MUL: begin
					if (mul_done && (mstep_q == mul_last)) begin
						state_q <= S_FWD_PIV;
					end
				end
				S_FWD_PIV: begin
					if (piv == '0) begin
						zero_seen_q <= 1'b1;
						wl_q        <= '0;
						wu_q        <= '0;
						wr_q        <= '0;
						state_q     <= S_FWD_WR;
					end else begin
						state_q <= S_FWD_DIV;
					end
				end
				S_FWD_DIV: begin
					if (div_done) begin
						wl_q    <= div_q0;
						wu_q    <= div_q1;
						wr_q    <= div_q2;
						state_q <= S_FWD_WR;
					end
				end
				S_FWD_WR: begin
					prev_lo_q   <= wl_q;
					prev_up_q   <= wu_q;
					prev_rh_q   <= wr_q;
					row_count_q <= row_count_q + CNT_W'(1);
					state_q     <= item_q.last_row ? S_CHECK : S_IDLE;
				end
				S_CHECK: begin
					if (row_count_q < CNT_W'(3)) begin
						err_q   <= ERR_FEW_ROWS;
						state_q <= S_ERR;
					end else if (zero_seen_q) begin
						err_q   <= ERR_ZERO_PIVOT;
						state_q <= S_ERR;
					end else begin
						rd_addr_q <= IDX_W'(row_count_q - CNT_W'(2));
						state_q   <= S_NX_RD;
					end
				end
				S_NX_RD: begin
					state_q <= S_NX_CAP;
				end
				S_NX_CAP: begin
					nx_lo_q <= rd_lo;
					nx_up_q <= rd_up;
					nx_rh_q <= rd_rh;
					if (row_count_q >= CNT_W'(4)) begin
						i_q       <= IDX_W'(row_count_q - CNT_W'(3));
						rd_addr_q <= IDX_W'(row_count_q - CNT_W'(3));
						state_q   <= S_BK_RD;
					end else begin
						rd_addr_q <= '0;
						state_q   <= S_FIN_RD;
					end
				end
				S_BK_RD: begin
					state_q <= S_BK_MUL;
				end
				S_BK_MUL: begin
					if (mul_done && (mstep_q == mul_last)) begin
						state_q <= S_BK_WR;
					end
				end
				S_BK_WR: begin
					nx_lo_q <= bk_lo;
					nx_up_q <= bk_up;
					nx_rh_q <= bk_rh;
					if (i_q == IDX_W'(1)) begin
						rd_addr_q <= '0;
						state_q   <= S_FIN_RD;
					end else begin
						i_q       <= i_q - IDX_W'(1);
						rd_addr_q <= i_q - IDX_W'(1);
						state_q   <= S_BK_RD;
					end
				end
				S_FIN_RD: begin
					state_q <= S_FIN_MUL;
				end
				S_FIN_MUL: begin
					if (mul_done && (mstep_q == mul_last)) begin
						state_q <= S_FIN_DEN;
					end
				end
				S_FIN_DEN: begin
					if (fin_den == '0) begin
						err_q   <= ERR_ZERO_PIVOT;
						state_q <= S_ERR;
					end else begin
						state_q <= S_FIN_DIV;
					end
				end
				S_FIN_DIV: begin
					if (div_done) begin
						wl_q    <= div_q0;
						wu_q    <= div_q1;
						wr_q    <= div_q2;
						state_q <= S_EMIT0;
					end
				end
				S_EMIT0: begin
					if (out_free) begin
						rd_addr_q <= IDX_W'(row_count_q - CNT_W'(1));
						state_q   <= S_LAST_RD;
					end
				end
				S_LAST_RD: begin
					state_q <= S_EMIT1;
				end
				S_EMIT1: begin
					if (out_free) begin
						block_ready_q <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				S_ERR: begin
					if (out_free) begin
						if (err_q != ERR_NO_BLOCK) begin
							row_count_q <= '0;
							zero_seen_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				S_B_FIRST: begin
					if (out_free) begin
						i_q       <= IDX_W'(1);
						rd_addr_q <= IDX_W'(1);
						state_q   <= S_B_RD;
					end
				end
				S_B_RD: begin
					state_q <= S_B_MUL;
				end
				S_B_MUL: begin
					if (mul_done && (mstep_q == mul_last)) begin
						state_q <= S_B_EMIT;
					end
				end
				S_B_EMIT: begin
					if (out_free) begin
						if ((CNT_W'(i_q) + CNT_W'(2)) < row_count_q) begin
							i_q       <= i_q + IDX_W'(1);
							rd_addr_q <= i_q + IDX_W'(1);
							state_q   <= S_B_RD;
						end else begin
							state_q <= S_B_LAST;
						end
					end
				end
				S_B_LAST: begin
					if (out_free) begin
						block_ready_q <= 1'b0;
						row_count_q   <= '0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: the next word loads as the current one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result_word  = result_q;

	// A reduced block always holds at least three rows and never more than the store.
	`TPR_ASSERT_HOLDS(a_ready_rows, !block_ready_q || ((row_count_q >= CNT_W'(3)) && (row_count_q <= CNT_W'(MAX_ROWS))), "reduced block with a bad row count")
	// A boundary word without a reduced block goes straight to the error word.
	`TPR_ASSERT_NEXT(a_no_block, accept && item_word.kind && !block_ready_q, (state_q == S_ERR) && (err_q == ERR_NO_BLOCK), "boundary word without block not flagged")
	// Multiplier results only arrive while a multiply step is waiting for them.
	`TPR_ASSERT_HOLDS(a_mul_owner, !mul_done || (state_q == S_FWD_MUL) || (state_q == S_BK_MUL) || (state_q == S_FIN_MUL) || (state_q == S_B_MUL), "multiplier result with no consumer")

endmodule

// ----- tb/sv/tridiagonal_partition_reducer_tb.sv -----
// Self-checking testbench for the tridiagonal partition reducer.
`timescale 1ns / 1ps
module tridiagonal_partition_reducer_tb;
	import tpr_pkg::*;

	// Predicts reduced rows, solutions and errors from accepted words and checks results.
	class reducer_scoreboard;
		word_t low_mem[MAX_ROWS];
		word_t up_mem[MAX_ROWS];
		word_t rhs_mem[MAX_ROWS];
		int rows;
		bit ready;
		bit pivot_zero;
		result_t pending[$];
		int errors;
		int checked;
		int items;

		function new();
			rows = 0;
			ready = 0;
			pivot_zero = 0;
			errors = 0;
			checked = 0;
			items = 0;
		endfunction

		function word_t magnitude(word_t x);
			return x[63] ? word_t'(0) - x : x;
		endfunction

		function word_t clamp(logic [127:0] m, bit neg);
			if (neg) return (m > 128'(FX_MIN)) ? FX_MIN : word_t'(0) - m[63:0];
			return (m > 128'(FX_MAX)) ? FX_MAX : m[63:0];
		endfunction

		function word_t sat_add(word_t a, word_t b);
			logic [64:0] s;
			s = {a[63], a} + {b[63], b};
			if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
			return s[63:0];
		endfunction

		function word_t sat_sub(word_t a, word_t b);
			logic [64:0] s;
			s = {a[63], a} - {b[63], b};
			if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
			return s[63:0];
		endfunction

		function word_t sat_neg(word_t a);
			return sat_sub(word_t'(0), a);
		endfunction

		// Rounded product, ties away from zero.
		function word_t fmul(word_t a, word_t b);
			logic [127:0] p;
			p = 128'(magnitude(a)) * 128'(magnitude(b));
			p = (p + (128'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
			return clamp(p, a[63] ^ b[63]);
		endfunction

		// Rounded quotient, ties away from zero; the divisor is never zero.
		function word_t fdiv(word_t n, word_t d);
			logic [127:0] num, dm, q, r;
			num = 128'(magnitude(n)) << FRAC_BITS;
			dm = 128'(magnitude(d));
			q = num / dm;
			r = num % dm;
			if (r >= dm - r) q = q + 1;
			return clamp(q, n[63] ^ d[63]);
		endfunction

		function void push(logic [1:0] k, word_t rl, word_t ru, word_t v, int idx,
				logic [1:0] err, bit lst);
			result_t r;
			r.out_kind = k;
			r.reduced_lower = rl;
			r.reduced_upper = ru;
			r.value = v;
			r.row_index = idx[5:0];
			r.error_code = err;
			r.last = lst;
			pending.push_back(r);
		endfunction

		// Forward elimination of one arriving row.
		function void eliminate(int i, word_t lo, word_t dg, word_t up, word_t rh);
			word_t piv;
			piv = dg;
			if (i >= 2) begin
				piv = sat_sub(dg, fmul(lo, up_mem[i-1]));
				rh = sat_sub(rh, fmul(lo, rhs_mem[i-1]));
				lo = sat_neg(fmul(lo, low_mem[i-1]));
			end
			if (piv == '0) begin
				pivot_zero = 1;
				low_mem[i] = '0;
				up_mem[i] = '0;
				rhs_mem[i] = '0;
			end else begin
				low_mem[i] = fdiv(lo, piv);
				up_mem[i] = fdiv(up, piv);
				rhs_mem[i] = fdiv(rh, piv);
			end
		endfunction

		function void note_item(item_t it);
			int n;
			word_t den, a0, c0, d0, s;
			items++;
			// Boundary word: back-substitute and emit every row's solution.
			if (it.kind) begin
				if (!ready) begin
					push(KIND_ERROR, '0, '0, '0, 0, ERR_NO_BLOCK, 1);
					return;
				end
				n = rows;
				push(KIND_SOLUTION, '0, '0, it.first_solution, 0, ERR_NONE, 0);
				for (int i = 1; i + 1 < n; i++) begin
					s = sat_add(fmul(low_mem[i], it.first_solution),
						fmul(up_mem[i], it.final_solution));
					push(KIND_SOLUTION, '0, '0, sat_sub(rhs_mem[i], s), i, ERR_NONE, 0);
				end
				push(KIND_SOLUTION, '0, '0, it.final_solution, n - 1, ERR_NONE, 1);
				ready = 0;
				rows = 0;
				return;
			end
			// Row word: a reduced block is discarded by a new row.
			if (ready) begin
				ready = 0;
				rows = 0;
				pivot_zero = 0;
			end
			if (rows < MAX_ROWS) begin
				eliminate(rows, it.lower, it.diag, it.upper, it.rhs);
				rows++;
			end
			if (!it.last_row) return;
			n = rows;
			if (n < 3 || pivot_zero) begin
				rows = 0;
				pivot_zero = 0;
				push(KIND_ERROR, '0, '0, '0, 0, (n < 3) ? ERR_FEW_ROWS : ERR_ZERO_PIVOT, 1);
				return;
			end
			// Backward elimination of the interior rows.
			for (int i = n - 3; i >= 1; i--) begin
				rhs_mem[i] = sat_sub(rhs_mem[i], fmul(up_mem[i], rhs_mem[i+1]));
				low_mem[i] = sat_sub(low_mem[i], fmul(up_mem[i], low_mem[i+1]));
				up_mem[i] = sat_neg(fmul(up_mem[i], up_mem[i+1]));
			end
			den = sat_sub(FX_ONE, fmul(low_mem[1], up_mem[0]));
			if (den == '0) begin
				rows = 0;
				pivot_zero = 0;
				push(KIND_ERROR, '0, '0, '0, 0, ERR_ZERO_PIVOT, 1);
				return;
			end
			d0 = fdiv(sat_sub(rhs_mem[0], fmul(up_mem[0], rhs_mem[1])), den);
			a0 = fdiv(low_mem[0], den);
			c0 = fdiv(sat_neg(fmul(up_mem[0], up_mem[1])), den);
			rhs_mem[0] = d0;
			low_mem[0] = a0;
			up_mem[0] = c0;
			ready = 1;
			push(KIND_REDUCED, a0, c0, d0, 0, ERR_NONE, 0);
			push(KIND_REDUCED, low_mem[n-1], up_mem[n-1], rhs_mem[n-1], n - 1, ERR_NONE, 1);
		endfunction

		function void check_result(result_t r);
			result_t e;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, r);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (r.out_kind != e.out_kind) begin
				$display("%0t: out_kind expected %0d actual %0d", $time, e.out_kind, r.out_kind);
				errors++;
			end
			if (r.reduced_lower != e.reduced_lower) begin
				$display("%0t: reduced_lower expected %h actual %h", $time,
					e.reduced_lower, r.reduced_lower);
				errors++;
			end
			if (r.reduced_upper != e.reduced_upper) begin
				$display("%0t: reduced_upper expected %h actual %h", $time,
					e.reduced_upper, r.reduced_upper);
				errors++;
			end
			if (r.value != e.value) begin
				$display("%0t: value expected %h actual %h", $time, e.value, r.value);
				errors++;
			end
			if (r.row_index != e.row_index) begin
				$display("%0t: row_index expected %0d actual %0d", $time,
					e.row_index, r.row_index);
				errors++;
			end
			if (r.error_code != e.error_code) begin
				$display("%0t: error_code expected %0d actual %0d", $time,
					e.error_code, r.error_code);
				errors++;
			end
			if (r.last != e.last) begin
				$display("%0t: last expected %0d actual %0d", $time, e.last, r.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic item_valid = 0;
	logic item_stall;
	item_t item_word = '0;
	logic result_valid;
	logic result_stall = 0;
	result_t result_word;

	reducer_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit long_hold = 0;
	int hold_count = 0;
	int quiet_cycles = 0;
	int blocks_sent = 0;

	tridiagonal_partition_reducer dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_word(item_word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_word(result_word)
	);

	always #5 clk = ~clk;

	// Receiver: random stalls, or one long hold-off counted here.
	always @(posedge clk) begin
		if (long_hold && hold_count < 600) begin
			result_stall <= 1;
			hold_count <= hold_count + 1;
		end else begin
			if (long_hold) long_hold <= 0;
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor: note accepted words and check results; watchdog on idle handshakes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) sb.note_item(item_word);
			if (result_valid && !result_stall) sb.check_result(result_word);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > 30000) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	// Fully random input word, every field filled.
	function automatic item_t rand_item();
		item_t w;
		w.kind = 1'($urandom_range(1));
		w.lower = rand_word();
		w.diag = rand_word();
		w.upper = rand_word();
		w.rhs = rand_word();
		w.last_row = 1'($urandom_range(1));
		w.first_solution = rand_word();
		w.final_solution = rand_word();
		return w;
	endfunction

	// Small coefficient in [-0.5, 0.5).
	function automatic word_t rand_coef();
		return word_t'($signed($urandom));
	endfunction

	// Diagonal of magnitude in [4, 13), with a random fraction and sign.
	function automatic word_t rand_diag();
		word_t d;
		d = (word_t'($urandom_range(4, 12)) << FRAC_BITS) | word_t'($urandom);
		return $urandom_range(1) ? word_t'(0) - d : d;
	endfunction

	function automatic word_t rand_value();
		return word_t'($signed(rand_word()) >>> $urandom_range(8, 30));
	endfunction

	task automatic send(item_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 0;
			item_word <= rand_item();
			@(posedge clk);
		end
		item_valid <= 1;
		item_word <= w;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic send_row(word_t lo, word_t dg, word_t up, word_t rh, bit lst);
		item_t w;
		w.kind = 0;
		w.lower = lo;
		w.diag = dg;
		w.upper = up;
		w.rhs = rh;
		w.last_row = lst;
		w.first_solution = rand_word();
		w.final_solution = rand_word();
		send(w);
	endtask

	task automatic send_boundary(word_t f, word_t l);
		item_t w;
		w = rand_item();
		w.kind = 1;
		w.first_solution = f;
		w.final_solution = l;
		send(w);
	endtask

	// A well-conditioned block of n rows.
	task automatic send_block(int n);
		for (int r = 0; r < n; r++)
			send_row(rand_coef(), rand_diag(), rand_coef(), rand_value(), r == n - 1);
		blocks_sent++;
	endtask

	task automatic send_noise();
		send(rand_item());
	endtask

	task automatic random_phase(int idle_pct, int stall_pct, int count);
		int sent;
		int n;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < count) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(3, 6);
			send_block(n);
			sent += n;
			case ($urandom_range(9))
				0: begin
					send_noise();
					sent++;
				end
				1: ;
				default: begin
					send_boundary(rand_word(), rand_word());
					sent++;
				end
			endcase
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: boundary with no block, too few rows, zero pivots.
		send_boundary(FX_MAX, FX_MIN);
		send_row(FX_MIN, FX_ONE, FX_MAX, FX_MIN, 1);
		send_row(FX_ONE, FX_ONE, FX_ONE, FX_ONE, 0);
		send_row(FX_ONE, FX_ONE, FX_ONE, FX_ONE, 1);
		send_row(FX_ONE, '0, FX_ONE, FX_ONE, 0);
		send_row(FX_ONE, FX_ONE, FX_ONE, FX_ONE, 0);
		send_row(FX_ONE, FX_ONE, FX_ONE, FX_ONE, 1);
		// Zero final denominator: a1 * c0 equals one.
		send_row('0, FX_ONE, FX_ONE, FX_ONE, 0);
		send_row(FX_ONE, FX_ONE, '0, FX_ONE, 0);
		send_row('0, FX_ONE, '0, FX_ONE, 1);
		// Saturating extremes in a three-row block, then its solutions.
		send_row(FX_MAX, FX_ONE, FX_MIN, FX_MAX, 0);
		send_row(FX_MIN, word_t'(1), FX_MAX, FX_MIN, 0);
		send_row(FX_MAX, FX_MIN, FX_MAX, FX_MAX, 1);
		send_boundary(FX_MIN, FX_MAX);
		// A reduced block discarded by a new one.
		send_block(3);
		send_block(4);
		send_boundary(FX_ONE, word_t'(0) - FX_ONE);
		send_boundary('0, '0);

		random_phase(0, 0, 15);
		random_phase(56, 0, 15);
		random_phase(0, 56, 15);

		// Overflowing block: the 65th row is dropped but still closes the block.
		send_idle_pct = 6;
		recv_stall_pct = 6;
		for (int r = 0; r <= MAX_ROWS; r++)
			send_row(rand_coef(), rand_diag(), rand_coef(), rand_value(), r == MAX_ROWS);
		blocks_sent++;
		// Long receiver hold-off while items keep coming.
		long_hold <= 1;
		send_boundary(rand_word(), rand_word());
		send_block(3);
		send_boundary(rand_word(), rand_word());
		send_noise();

		random_phase(6, 6, 10);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		item_valid <= 0;

		// Let the monitor note the last accepted word before waiting on the queue.
		@(posedge clk);
		wait (sb.pending.size() == 0);
		repeat (300) @(posedge clk);
		$display("Run covered %0d input words in %0d row blocks and %0d checked results,",
			sb.items, blocks_sent, sb.checked);
		$display("including error cases, saturation, an overflowing block and a long stall.");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+src
src/tpr_pkg.sv
src/tpr_ram.sv
src/tpr_mul.sv
src/tpr_div.sv
src/tridiagonal_partition_reducer.sv
tb/sv/tridiagonal_partition_reducer_tb.sv
